/* hw/rtl/isbb_pkg.sv */
// shared types and constants for the interval sphere bounding box
package isbb_pkg;

  localparam int NUM_ENTRIES = 12;
  localparam int IDX_W       = 4;

  // request kinds
  localparam logic KIND_ENTRY  = 1'b0;
  localparam logic KIND_SPHERE = 1'b1;

  // saturation limits, also the empty group merge values
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // load enables of the product and scaled term registers
  typedef struct packed {
    logic ld_prod;
    logic ld_term;
  } pipe_ctl_t;

endpackage

/* hw/rtl/interval_sphere_bounding_box_top.sv */
// interval transform of spheres into axis-aligned boxes, with optional group merge
// a sphere request goes through input, product, term and output registers to its box
// one request per cycle unless stalled; the 18 bound multipliers are fully pipelined
// entry writes update the transform at the edge they are accepted and give no box
// reset: transform entries go to zero, group merge to empty, mode to one box per sphere
// a full pipeline stalls requests only while a finished box waits on the output
module interval_sphere_bounding_box_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                kind,
  input  logic [3:0]          entry_index,
  input  logic signed [31:0]  entry_low,
  input  logic signed [31:0]  entry_high,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  center_z,
  input  logic [30:0]         radius,
  input  logic                last_key,
  output logic                box_valid,
  input  logic                box_stall,
  output logic signed [31:0]  box_min_x,
  output logic signed [31:0]  box_min_y,
  output logic signed [31:0]  box_min_z,
  output logic signed [31:0]  box_max_x,
  output logic signed [31:0]  box_max_y,
  output logic signed [31:0]  box_max_z
);

  localparam int TERM_W = 64 - FRAC_BITS;
  localparam int ACC_W  = TERM_W + 3;

  logic                      group_mode;
  logic signed [31:0]        tf_low  [isbb_pkg::NUM_ENTRIES];
  logic signed [31:0]        tf_high [isbb_pkg::NUM_ENTRIES];

  logic                      s1_valid;
  logic signed [31:0]        s1_center [3];
  logic [30:0]               s1_radius;
  logic                      s1_last;

  logic                      s2_valid;
  logic [30:0]               s2_radius;
  logic                      s2_last;
  logic signed [31:0]        s2_trans_low  [3];
  logic signed [31:0]        s2_trans_high [3];

  logic                      s3_valid;
  logic [30:0]               s3_radius;
  logic                      s3_last;
  logic signed [31:0]        s3_trans_low  [3];
  logic signed [31:0]        s3_trans_high [3];

  logic signed [TERM_W-1:0]  term_low  [3][3];
  logic signed [TERM_W-1:0]  term_high [3][3];

  logic signed [ACC_W-1:0]   acc_low  [3];
  logic signed [ACC_W-1:0]   acc_high [3];
  logic signed [31:0]        bmin [3];
  logic signed [31:0]        bmax [3];
  logic signed [31:0]        mrg_min [3];
  logic signed [31:0]        mrg_max [3];
  logic signed [31:0]        group_min [3];
  logic signed [31:0]        group_max [3];
  logic signed [31:0]        box_min [3];
  logic signed [31:0]        box_max [3];
  logic signed [31:0]        rad_s;

  logic                      ld_out;
  logic                      ld_in;
  logic                      req_acc;
  logic                      emit;
  isbb_pkg::pipe_ctl_t       pipe_ctl;

  function automatic logic signed [31:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(isbb_pkg::Q_MAX)) begin
      r = isbb_pkg::Q_MAX;
    end else if (v < ACC_W'(isbb_pkg::Q_MIN)) begin
      r = isbb_pkg::Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // each stage moves when the one after it moves or is empty
  assign ld_out           = !box_valid || !box_stall;
  assign pipe_ctl.ld_term = ld_out || !s3_valid;
  assign pipe_ctl.ld_prod = pipe_ctl.ld_term || !s2_valid;
  assign ld_in            = pipe_ctl.ld_prod || !s1_valid;
  assign req_stall        = !ld_in;
  assign req_acc          = req_valid && ld_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      group_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < isbb_pkg::NUM_ENTRIES; i++) begin
        tf_low[i]  <= '0;
        tf_high[i] <= '0;
      end
    end else if (req_acc && kind == isbb_pkg::KIND_ENTRY &&
                 entry_index < isbb_pkg::IDX_W'(isbb_pkg::NUM_ENTRIES)) begin
      tf_low[entry_index]  <= entry_low;
      tf_high[entry_index] <= entry_high;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ld_in) begin
        s1_valid <= req_valid && kind == isbb_pkg::KIND_SPHERE;
      end
      if (pipe_ctl.ld_prod) begin
        s2_valid <= s1_valid;
      end
      if (pipe_ctl.ld_term) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // pipeline payload; translation is sampled with the products
  always_ff @(posedge clk) begin
    if (ld_in) begin
      s1_center[0] <= center_x;
      s1_center[1] <= center_y;
      s1_center[2] <= center_z;
      s1_radius    <= radius;
      s1_last      <= last_key;
    end
    if (pipe_ctl.ld_prod) begin
      s2_radius <= s1_radius;
      s2_last   <= s1_last;
      for (int ax = 0; ax < 3; ax++) begin
        s2_trans_low[ax]  <= tf_low[ax*4+3];
        s2_trans_high[ax] <= tf_high[ax*4+3];
      end
    end
    if (pipe_ctl.ld_term) begin
      s3_radius     <= s2_radius;
      s3_last       <= s2_last;
      s3_trans_low  <= s2_trans_low;
      s3_trans_high <= s2_trans_high;
    end
  end

  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    for (genvar j = 0; j < 3; j++) begin : g_term
      isbb_term #(
        .FRAC_BITS(FRAC_BITS)
      ) u_term (
        .clk       (clk),
        .ctl       (pipe_ctl),
        .ent_low   (tf_low[ax*4+j]),
        .ent_high  (tf_high[ax*4+j]),
        .coord     (s1_center[j]),
        .term_low  (term_low[ax][j]),
        .term_high (term_high[ax][j])
      );
    end
  end

  assign rad_s = $signed({1'b0, s3_radius});
  assign emit  = !group_mode || s3_last;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      acc_low[ax]  = ACC_W'(s3_trans_low[ax]) + ACC_W'(term_low[ax][0])
                   + ACC_W'(term_low[ax][1]) + ACC_W'(term_low[ax][2]) - ACC_W'(rad_s);
      acc_high[ax] = ACC_W'(s3_trans_high[ax]) + ACC_W'(term_high[ax][0])
                   + ACC_W'(term_high[ax][1]) + ACC_W'(term_high[ax][2]) + ACC_W'(rad_s);
      bmin[ax]     = sat_q(acc_low[ax]);
      bmax[ax]     = sat_q(acc_high[ax]);
      mrg_min[ax]  = (bmin[ax] < group_min[ax]) ? bmin[ax] : group_min[ax];
      mrg_max[ax]  = (bmax[ax] > group_max[ax]) ? bmax[ax] : group_max[ax];
    end
  end

  // output valid and group merge state
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
      for (int ax = 0; ax < 3; ax++) begin
        group_min[ax] <= isbb_pkg::Q_MAX;
        group_max[ax] <= isbb_pkg::Q_MIN;
      end
    end else if (ld_out) begin
      box_valid <= s3_valid && emit;
      if (s3_valid && group_mode) begin
        for (int ax = 0; ax < 3; ax++) begin
          // last key closes the group and restarts the merge
          group_min[ax] <= s3_last ? isbb_pkg::Q_MAX : mrg_min[ax];
          group_max[ax] <= s3_last ? isbb_pkg::Q_MIN : mrg_max[ax];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out && s3_valid) begin
      for (int ax = 0; ax < 3; ax++) begin
        box_min[ax] <= group_mode ? mrg_min[ax] : bmin[ax];
        box_max[ax] <= group_mode ? mrg_max[ax] : bmax[ax];
      end
    end
  end

  assign box_min_x = box_min[0];
  assign box_min_y = box_min[1];
  assign box_min_z = box_min[2];
  assign box_max_x = box_max[0];
  assign box_max_y = box_max[1];
  assign box_max_z = box_max[2];

endmodule

/* hw/rtl/isbb_term.sv */
// one interval product term: bound select, registered multiply, directed rounding
module isbb_term #(
  parameter int FRAC_BITS = 16,
  localparam int TERM_W = 64 - FRAC_BITS
) (
  input  logic                     clk,
  input  isbb_pkg::pipe_ctl_t      ctl,
  input  logic signed [31:0]       ent_low,
  input  logic signed [31:0]       ent_high,
  input  logic signed [31:0]       coord,
  output logic signed [TERM_W-1:0] term_low,
  output logic signed [TERM_W-1:0] term_high
);

  localparam int PROD_W = 64;
  localparam logic signed [PROD_W-1:0] ROUND_UP =
    PROD_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);

  logic signed [31:0]       op_low;
  logic signed [31:0]       op_high;
  logic signed [PROD_W-1:0] prod_low;
  logic signed [PROD_W-1:0] prod_high;
  logic signed [PROD_W-1:0] up_sum;
  logic signed [PROD_W-1:0] low_shift;
  logic signed [PROD_W-1:0] high_shift;

  // a negative coordinate swaps which bound gives the low side
  always_comb begin
    op_low  = coord[31] ? ent_high : ent_low;
    op_high = coord[31] ? ent_low  : ent_high;
  end

  // floor for the low side, ceiling for the high side
  always_comb begin
    low_shift  = prod_low >>> FRAC_BITS;
    up_sum     = prod_high + ROUND_UP;
    high_shift = up_sum >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_low  <= PROD_W'(op_low) * PROD_W'(coord);
      prod_high <= PROD_W'(op_high) * PROD_W'(coord);
    end
    if (ctl.ld_term) begin
      term_low  <= low_shift[TERM_W-1:0];
      term_high <= high_shift[TERM_W-1:0];
    end
  end

endmodule

/* hw/rtl/isbb_checker.sv */
// port-level checks of the bounding box block, bound to the top level
module isbb_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_stall,
  input logic               box_valid,
  input logic               box_stall,
  input logic signed [31:0] box_min_x,
  input logic signed [31:0] box_min_y,
  input logic signed [31:0] box_min_z,
  input logic signed [31:0] box_max_x,
  input logic signed [31:0] box_max_y,
  input logic signed [31:0] box_max_z
);

  // no box right after a reset edge
  a_reset_empty: assert property (@(posedge clk) rst |=> !box_valid)
    else $error("box valid after reset");

  // requests back up only while a valid box is stalled on the output
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> box_valid && box_stall)
    else $error("request stalled with room in the pipeline");

  a_box_held: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_stall |=> box_valid)
    else $error("stalled box dropped");

  a_box_stable: assert property (@(posedge clk) disable iff (rst)
    box_valid && box_stall |=> $stable(box_min_x) && $stable(box_min_y) &&
      $stable(box_min_z) && $stable(box_max_x) && $stable(box_max_y) &&
      $stable(box_max_z))
    else $error("stalled box changed");

endmodule

bind interval_sphere_bounding_box_top isbb_checker u_isbb_checker (.*);
